### hdl/cosine_similarity_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cosine similarity unit.
// Concurrent checks are compiled for simulation only.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define CSU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset
`define CSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSU_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/csu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_pkg
// Shared widths, limits and transaction types of the cosine similarity unit.
// ----------------------------------------------------------------------------
package csu_pkg;

  localparam int ELEM_WIDTH      = 16;
  localparam int SIM_WIDTH       = 16;
  localparam int FRAC_BITS       = 15;
  localparam int SUM_WIDTH       = 41;
  localparam int PROD_WIDTH      = 2 * SUM_WIDTH;
  localparam int ROOT_WIDTH      = SUM_WIDTH;
  localparam int QUOT_WIDTH      = FRAC_BITS + 1;
  localparam int STEP_WIDTH      = $clog2(SUM_WIDTH);
  localparam int MAX_LEN_DEF     = 1024;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Saturation limits of the running sums
  localparam logic [SUM_WIDTH-1:0] DOT_MAX  = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] DOT_MIN  = {1'b1, {(SUM_WIDTH-1){1'b0}}};
  localparam logic [SUM_WIDTH-1:0] NORM_MAX = {SUM_WIDTH{1'b1}};

  // Clamp limits of the quotient magnitude and the Q1.15 result
  localparam logic [QUOT_WIDTH-1:0] POS_LIMIT = QUOT_WIDTH'(2**(SIM_WIDTH-1) - 1);
  localparam logic [QUOT_WIDTH-1:0] NEG_LIMIT = QUOT_WIDTH'(2**(SIM_WIDTH-1));
  localparam logic [SIM_WIDTH-1:0]  SIM_MAX   = {1'b0, {(SIM_WIDTH-1){1'b1}}};
  localparam logic [SIM_WIDTH-1:0]  SIM_MIN   = {1'b1, {(SIM_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_WIDTH-1:0] elem_a;
    logic signed [ELEM_WIDTH-1:0] elem_b;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic signed [SIM_WIDTH-1:0] similarity;
    logic                        zero_vector;
    logic                        too_long;
  } out_item_t;

  // Finished sums of one vector pair, handed from front to back
  typedef struct packed {
    logic signed [SUM_WIDTH-1:0] dot;
    logic [SUM_WIDTH-1:0]        norm_a;
    logic [SUM_WIDTH-1:0]        norm_b;
    logic                        too_long;
  } job_t;

  typedef struct packed {
    logic empty;
    logic almost_full;
    logic full;
  } queue_status_t;

endpackage

### hdl/csu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csu_front
// Accepts element pairs, forms the products and keeps the saturating sums;
// pushes the finished sums of a vector pair into the job queue.
// ----------------------------------------------------------------------------
module csu_front #(
  parameter int MAX_LEN = csu_pkg::MAX_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  csu_pkg::in_item_t      item,
  input  csu_pkg::queue_status_t q_status,
  output logic                   push,
  output csu_pkg::job_t          push_job
);
  import csu_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int PW    = 2 * ELEM_WIDTH;

  logic                    accept;
  logic signed [PW-1:0]    mul_dot;
  logic signed [PW-1:0]    mul_aa;
  logic signed [PW-1:0]    mul_bb;

  logic                    s1_valid;
  logic                    s1_last;
  logic signed [PW-1:0]    p_dot;
  logic [PW-2:0]           p_sq_a;
  logic [PW-2:0]           p_sq_b;

  logic [SUM_WIDTH-1:0]    dot_sum;
  logic [SUM_WIDTH-1:0]    norm_a_sum;
  logic [SUM_WIDTH-1:0]    norm_b_sum;
  logic [CNT_W-1:0]        elem_count;
  logic                    overflow_seen;

  logic signed [SUM_WIDTH:0] dot_wide;
  logic [SUM_WIDTH:0]        na_wide;
  logic [SUM_WIDTH:0]        nb_wide;
  logic [SUM_WIDTH-1:0]      dot_sum_next;
  logic [SUM_WIDTH-1:0]      norm_a_sum_next;
  logic [SUM_WIDTH-1:0]      norm_b_sum_next;
  logic [CNT_W-1:0]          elem_count_next;
  logic                      overflow_seen_next;
  logic                      at_max;

  // Hold off when the queue could not take the sums of a last pair
  assign item_ready = !q_status.full && !(s1_valid && s1_last && q_status.almost_full);
  assign accept     = item_valid && item_ready;

  // Form the three products of the incoming pair
  assign mul_dot = $signed(item.elem_a) * $signed(item.elem_b);
  assign mul_aa  = $signed(item.elem_a) * $signed(item.elem_a);
  assign mul_bb  = $signed(item.elem_b) * $signed(item.elem_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
    end else begin
      s1_valid <= accept;
      s1_last  <= accept && item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_dot  <= mul_dot;
      p_sq_a <= mul_aa[PW-2:0];
      p_sq_b <= mul_bb[PW-2:0];
    end
  end

  // Add the products into the sums and saturate
  always_comb begin
    dot_wide = $signed({{(SUM_WIDTH + 1 - PW){p_dot[PW-1]}}, p_dot})
             + $signed({dot_sum[SUM_WIDTH-1], dot_sum});
    na_wide  = {1'b0, norm_a_sum} + (SUM_WIDTH + 1)'(p_sq_a);
    nb_wide  = {1'b0, norm_b_sum} + (SUM_WIDTH + 1)'(p_sq_b);

    if (dot_wide[SUM_WIDTH] != dot_wide[SUM_WIDTH-1]) begin
      dot_sum_next = dot_wide[SUM_WIDTH] ? DOT_MIN : DOT_MAX;
    end else begin
      dot_sum_next = dot_wide[SUM_WIDTH-1:0];
    end
    norm_a_sum_next = na_wide[SUM_WIDTH] ? NORM_MAX : na_wide[SUM_WIDTH-1:0];
    norm_b_sum_next = nb_wide[SUM_WIDTH] ? NORM_MAX : nb_wide[SUM_WIDTH-1:0];

    at_max             = (elem_count == CNT_W'(MAX_LEN));
    elem_count_next    = at_max ? elem_count : elem_count + 1'b1;
    overflow_seen_next = overflow_seen || at_max;
  end

  // Advance the sums; clear them after the last pair of a vector
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum       <= '0;
      norm_a_sum    <= '0;
      norm_b_sum    <= '0;
      elem_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (s1_valid) begin
      if (s1_last) begin
        dot_sum       <= '0;
        norm_a_sum    <= '0;
        norm_b_sum    <= '0;
        elem_count    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        dot_sum       <= dot_sum_next;
        norm_a_sum    <= norm_a_sum_next;
        norm_b_sum    <= norm_b_sum_next;
        elem_count    <= elem_count_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

  // Hand the finished sums to the queue
  assign push              = s1_valid && s1_last;
  assign push_job.dot      = $signed(dot_sum_next);
  assign push_job.norm_a   = norm_a_sum_next;
  assign push_job.norm_b   = norm_b_sum_next;
  assign push_job.too_long = overflow_seen_next;

endmodule

### hdl/csu_queue.sv
`timescale 1ns / 1ps
`include "cosine_similarity_unit_assert.svh"
// ----------------------------------------------------------------------------
// csu_queue
// Short job queue between the accumulating front and the arithmetic back.
// ----------------------------------------------------------------------------
module csu_queue #(
  parameter int DEPTH = csu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  csu_pkg::job_t          push_job,
  input  logic                   pop,
  output csu_pkg::job_t          pop_job,
  output csu_pkg::queue_status_t status
);
  import csu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Write the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  assign pop_job = mem[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign status.empty       = (count == '0);
  assign status.full        = (count == CNT_W'(DEPTH));
  assign status.almost_full = (count == CNT_W'(DEPTH - 1));

  `CSU_ASSERT_IMPL(a_no_overrun, clk, rst, push, !status.full, "job pushed into full queue")
  `CSU_ASSERT_IMPL(a_no_underrun, clk, rst, pop, !status.empty, "job popped from empty queue")
  `CSU_ASSERT_NEXT(a_push_fills, clk, rst, push && !pop, !status.empty, "queue empty after push")

endmodule

### hdl/csu_back.sv
`timescale 1ns / 1ps
`include "cosine_similarity_unit_assert.svh"
// ----------------------------------------------------------------------------
// csu_back
// Takes finished sums from the queue: multiplies the norms, takes the
// integer square root, divides and clamps, then holds the result.
// ----------------------------------------------------------------------------
module csu_back (
  input  logic                   clk,
  input  logic                   rst,
  input  csu_pkg::queue_status_t q_status,
  input  csu_pkg::job_t          job,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_ready,
  output csu_pkg::out_item_t     result
);
  import csu_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_SQRT  = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_DONE  = 6'b100000
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic [STEP_WIDTH-1:0]   step;
  logic                    neg;
  logic                    zero;
  logic                    too_long;
  logic [SUM_WIDTH-1:0]    dmag;
  logic [PROD_WIDTH-1:0]   mcand;
  logic [SUM_WIDTH-1:0]    mplier;
  logic [PROD_WIDTH-1:0]   prod;
  logic [ROOT_WIDTH-1:0]   root;
  logic [ROOT_WIDTH+1:0]   rem;
  logic [ROOT_WIDTH-1:0]   div_rem;
  logic [QUOT_WIDTH-1:0]   dbits;
  logic [QUOT_WIDTH-1:0]   quot;

  logic                    load;
  logic                    last_step;
  logic                    job_zero;
  logic                    job_neg;
  logic [ROOT_WIDTH+3:0]   rem_sh;
  logic [ROOT_WIDTH+3:0]   trial;
  logic                    sq_ge;
  logic [ROOT_WIDTH+3:0]   sq_diff;
  logic [ROOT_WIDTH:0]     div_sh;
  logic                    div_ge;
  logic [ROOT_WIDTH:0]     div_diff;
  logic [SUM_WIDTH-2:0]    dmag_hi;
  logic                    sat;
  logic [SIM_WIDTH-1:0]    sim_val;

  assign pop       = (state == ST_IDLE) && !q_status.empty;
  assign load      = (state == ST_DONE) && (!result_valid || result_ready);
  assign job_zero  = (job.norm_a == '0) || (job.norm_b == '0);
  assign job_neg   = job.dot[SUM_WIDTH-1];
  assign dmag_hi   = dmag[SUM_WIDTH-1:1];
  assign sat       = ROOT_WIDTH'(dmag_hi) >= root;

  // One root digit per step
  assign rem_sh  = {rem, prod[PROD_WIDTH-1 -: 2]};
  assign trial   = (ROOT_WIDTH + 4)'({root, 2'b01});
  assign sq_ge   = rem_sh >= trial;
  assign sq_diff = rem_sh - trial;

  // One quotient bit per step
  assign div_sh   = {div_rem, dbits[QUOT_WIDTH-1]};
  assign div_ge   = div_sh >= (ROOT_WIDTH + 1)'(root);
  assign div_diff = div_sh - (ROOT_WIDTH + 1)'(root);

  always_comb begin
    case (state)
      ST_MUL, ST_SQRT: last_step = (step == STEP_WIDTH'(SUM_WIDTH - 1));
      ST_DIV:          last_step = (step == STEP_WIDTH'(QUOT_WIDTH - 1));
      default:         last_step = 1'b0;
    endcase
  end

  // Sequence the job through the shared steps
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          state_next = job_zero ? ST_DONE : ST_MUL;
        end
      end
      ST_MUL: begin
        if (last_step) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (last_step) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = sat ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        if (last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state != state_next || last_step) begin
        step <= '0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  // Datapath registers per state
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          neg      <= job_neg && !job_zero;
          zero     <= job_zero;
          too_long <= job.too_long;
          dmag     <= job_neg ? SUM_WIDTH'(~job.dot + 1'b1) : job.dot;
          mcand    <= PROD_WIDTH'(job.norm_a);
          mplier   <= job.norm_b;
          prod     <= '0;
          quot     <= '0;
        end
      end
      ST_MUL: begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= {mcand[PROD_WIDTH-2:0], 1'b0};
        mplier <= {1'b0, mplier[SUM_WIDTH-1:1]};
        root   <= '0;
        rem    <= '0;
      end
      ST_SQRT: begin
        prod <= {prod[PROD_WIDTH-3:0], 2'b00};
        if (sq_ge) begin
          rem  <= sq_diff[ROOT_WIDTH+1:0];
          root <= {root[ROOT_WIDTH-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[ROOT_WIDTH+1:0];
          root <= {root[ROOT_WIDTH-2:0], 1'b0};
        end
      end
      ST_CHECK: begin
        div_rem <= ROOT_WIDTH'(dmag_hi);
        dbits   <= {dmag[0], {(QUOT_WIDTH-1){1'b0}}};
        quot    <= sat ? {QUOT_WIDTH{1'b1}} : '0;
      end
      ST_DIV: begin
        dbits <= {dbits[QUOT_WIDTH-2:0], 1'b0};
        if (div_ge) begin
          div_rem <= div_diff[ROOT_WIDTH-1:0];
          quot    <= {quot[QUOT_WIDTH-2:0], 1'b1};
        end else begin
          div_rem <= div_sh[ROOT_WIDTH-1:0];
          quot    <= {quot[QUOT_WIDTH-2:0], 1'b0};
        end
      end
      default: begin
        quot <= quot;
      end
    endcase
  end

  // Clamp the signed quotient to Q1.15
  always_comb begin
    if (neg) begin
      sim_val = (quot > NEG_LIMIT) ? SIM_MIN : SIM_WIDTH'(~quot + 1'b1);
    end else begin
      sim_val = (quot > POS_LIMIT) ? SIM_MAX : SIM_WIDTH'(quot);
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.similarity  <= $signed(sim_val);
      result.zero_vector <= zero;
      result.too_long    <= too_long;
    end
  end

  `CSU_ASSERT_IMPL(a_state_onehot, clk, rst, 1'b1, $onehot(state), "back state not one-hot")
  `CSU_ASSERT_IMPL(a_zero_result, clk, rst, result_valid && result.zero_vector, result.similarity == '0, "zero vector with nonzero similarity")
  `CSU_ASSERT_IMPL(a_pop_idle_only, clk, rst, pop, state == ST_IDLE, "job taken while busy")
  `CSU_ASSERT_NEXT(a_load_shows, clk, rst, load, result_valid && state == ST_IDLE, "loaded result not presented")

endmodule

### hdl/cosine_similarity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_unit
// Streaming cosine similarity of two Q1.15 vectors, one result per vector.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_ready / item) carries one element pair
//   per transaction; item.last closes the vector pair. The result channel
//   (result_valid / result_ready / result) carries one transaction per
//   vector pair: similarity in Q1.15, zero_vector and too_long flags.
//   The front takes one element pair per cycle while item_ready is high;
//   its sums for a closed vector pair enter a job queue of QUEUE_DEPTH
//   entries. The back handles one job at a time: it takes the job from the
//   queue, forms the norm product by shift-add, takes its square root,
//   makes one range check, divides and loads the result register; a
//   saturating quotient skips the division and a zero-norm pair goes
//   straight to the load. It takes no new job before the last is loaded.
//   When the receiver stalls the result register holds, the back waits
//   with its next result, the queue fills, and then item_ready drops.
//   Reset clears the sums, the queue and the result valid flag.
// ----------------------------------------------------------------------------
module cosine_similarity_unit #(
  parameter int MAX_LEN     = csu_pkg::MAX_LEN_DEF,
  parameter int QUEUE_DEPTH = csu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  csu_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output csu_pkg::out_item_t result
);
  import csu_pkg::*;

  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          pop_job;
  queue_status_t q_status;

  // Accumulate element pairs
  csu_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_status   (q_status),
    .push       (push),
    .push_job   (push_job)
  );

  // Buffer finished sums
  csu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  // Root, divide and clamp
  csu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .job          (pop_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

### dv/cosine_similarity_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_unit_test
// Self-checking bench for the streaming cosine similarity unit. Element
// pairs go in through the item channel with random gaps, and results come
// back through a randomly stalled result channel. A scoreboard tracks the
// running dot product and squared norms, which saturate as the block does.
// From them it derives the expected Q1.15 similarity and the flags. Each
// result is checked against the oldest expected one. The stimulus covers
// single-pair vectors at full scale, zero-norm vectors, parallel and
// opposite vectors, and full-scale runs that clamp the result.
// ----------------------------------------------------------------------------
module cosine_similarity_unit_test;
  import csu_pkg::*;

  localparam int          MAX_LEN     = MAX_LEN_DEF;
  localparam int          SHORT_ITEMS = 880;
  localparam int          DRAIN_WAIT  = 150;
  localparam longint      DOT_HI      = 64'sh0000_00FF_FFFF_FFFF;
  localparam longint      DOT_LO      = -64'sh0000_0100_0000_0000;
  localparam longint unsigned NORM_HI = 64'h0000_01FF_FFFF_FFFF;

  typedef enum int {
    VEC_RANDOM,
    VEC_SMALL,
    VEC_EXTREME,
    VEC_SAME,
    VEC_OPPOSITE,
    VEC_ZERO_A,
    VEC_ZERO_B,
    VEC_FULL_POS,
    VEC_FULL_NEG
  } vec_kind_t;

  // Running sums of the current vector pair and the queue of results owed
  class cosine_tracker;
    longint          dot_acc;
    longint unsigned norm_a_acc;
    longint unsigned norm_b_acc;
    int              pair_count;
    bit              over_len;
    out_item_t       pending_similarities[$];
    int              mismatches;
    int              pairs_seen;
    int              vectors_done;
    int              zero_done;
    int              long_done;
    int              clamped_done;

    // Accumulate one accepted element pair; on last, queue the expected result
    function void take_pair(in_item_t it);
      longint          a, b, d, s;
      longint unsigned na, nb, mag, q, root;
      bit [127:0]      prod, trial, r;
      out_item_t       want;
      a = $signed(it.elem_a);
      b = $signed(it.elem_b);
      pairs_seen++;
      if (pair_count >= MAX_LEN) over_len = 1'b1;
      else pair_count++;

      d = dot_acc + a * b;
      if (d > DOT_HI) d = DOT_HI;
      if (d < DOT_LO) d = DOT_LO;
      dot_acc = d;
      na = norm_a_acc + longint'(a * a);
      nb = norm_b_acc + longint'(b * b);
      norm_a_acc = (na > NORM_HI) ? NORM_HI : na;
      norm_b_acc = (nb > NORM_HI) ? NORM_HI : nb;
      if (!it.last) return;

      want = '0;
      if (norm_a_acc == 0 || norm_b_acc == 0) begin
        want.zero_vector = 1'b1;
        zero_done++;
      end else begin
        // floor square root of the exact norm product, bit by bit
        prod = 128'(norm_a_acc) * 128'(norm_b_acc);
        r = '0;
        for (int k = 42; k >= 0; k--) begin
          trial = r | (128'd1 << k);
          if (trial * trial <= prod) r = trial;
        end
        root = r[63:0];
        mag = (dot_acc < 0) ? -dot_acc : dot_acc;
        mag = mag << FRAC_BITS;
        q = mag / root;
        // truncate toward zero, then clamp into Q1.15
        if (dot_acc < 0) begin
          if (q > 32768) clamped_done++;
          s = (q > 32768) ? -32768 : -longint'(q);
        end else begin
          if (q > 32767) clamped_done++;
          s = (q > 32767) ? 32767 : longint'(q);
        end
        want.similarity = s[15:0];
      end
      want.too_long = over_len;
      if (over_len) long_done++;
      pending_similarities.push_back(want);
      vectors_done++;

      dot_acc = 0;
      norm_a_acc = 0;
      norm_b_acc = 0;
      pair_count = 0;
      over_len = 1'b0;
    endfunction

    // Compare one accepted result with the oldest expectation
    function void match_result(out_item_t got);
      out_item_t want;
      if (pending_similarities.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: sim=%0d zero=%0b long=%0b", $realtime,
                   $signed(got.similarity), got.zero_vector, got.too_long);
        return;
      end
      want = pending_similarities.pop_front();
      if (got.similarity !== want.similarity || got.zero_vector !== want.zero_vector ||
          got.too_long !== want.too_long) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result mismatch: expected sim=%0d zero=%0b long=%0b, got sim=%0d zero=%0b long=%0b",
                   $realtime, $signed(want.similarity), want.zero_vector, want.too_long,
                   $signed(got.similarity), got.zero_vector, got.too_long);
      end
    endfunction

    function int outstanding();
      return pending_similarities.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_ready;
  in_item_t  item;
  logic      result_valid;
  logic      result_ready;
  out_item_t result;

  cosine_tracker tracker = new();

  cosine_similarity_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // Observe both channels
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) tracker.take_pair(item);
    if (!rst && result_valid && result_ready) tracker.match_result(result);
  end

  // Stall the result channel at random, with stall-free stretches
  initial begin
    int stall;
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  // Offer one element pair and hold it until accepted
  task automatic send_pair(input logic signed [ELEM_WIDTH-1:0] a,
                           input logic signed [ELEM_WIDTH-1:0] b,
                           input bit last, input bit steady);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{elem_a: a, elem_b: b, last: last};
    do @(posedge clk); while (!(item_valid && item_ready));
  endtask

  // Hold off the sender until every owed result has come back
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  function automatic logic signed [ELEM_WIDTH-1:0] draw_elem(vec_kind_t kind);
    if (kind == VEC_SMALL) return ELEM_WIDTH'(int'($urandom_range(0, 16)) - 8);
    if (kind == VEC_EXTREME) begin
      case ($urandom_range(0, 4))
        0: return 16'sh8000;
        1: return 16'sh7FFF;
        2: return -16'sd1;
        3: return 16'sd0;
        default: return 16'sd1;
      endcase
    end
    return ELEM_WIDTH'($urandom_range(0, 65535));
  endfunction

  // Stream one vector pair of the given length and shape
  task automatic send_vector(input int len, input vec_kind_t kind, input bit steady);
    logic signed [ELEM_WIDTH-1:0] a, b;
    for (int i = 0; i < len; i++) begin
      a = draw_elem(kind);
      case (kind)
        VEC_SAME:     b = a;
        VEC_OPPOSITE: b = -a;
        VEC_ZERO_A: begin
          b = a;
          a = '0;
        end
        VEC_ZERO_B:   b = '0;
        VEC_FULL_POS: begin
          a = 16'sh8000;
          b = 16'sh8000;
        end
        VEC_FULL_NEG: begin
          a = 16'sh8000;
          b = 16'sh7FFF;
        end
        default:      b = draw_elem(kind);
      endcase
      send_pair(a, b, i == len - 1, steady);
    end
  endtask

  // Reset, directed cases, random vector pairs, then wind down
  initial begin
    int        short_items;
    int        vec_idx;
    int        len;
    int        pick;
    vec_kind_t kind;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single pairs: full scale clamps high, mixed signs, zero norms, unit size
    send_pair(16'sh8000, 16'sh8000, 1'b1, 1'b0);
    send_pair(16'sh7FFF, 16'sh8000, 1'b1, 1'b0);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
    send_pair(16'sd0, 16'sd12345, 1'b1, 1'b0);
    send_pair(-16'sd1, 16'sd0, 1'b1, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b1, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b1, 1'b1);
    // orthogonal pair of length two
    send_pair(16'sd1, 16'sd0, 1'b0, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b1, 1'b0);
    // mixed extremes over several pairs
    send_pair(16'sh7FFF, 16'sd1, 1'b0, 1'b1);
    send_pair(16'sh8000, -16'sd1, 1'b0, 1'b1);
    send_pair(16'sd1, 16'sh7FFF, 1'b1, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
    send_pair(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
    send_pair(-16'sd1, -16'sd1, 1'b1, 1'b0);
    // a zero-norm vector of two pairs
    send_pair(16'sd0, 16'sh5555, 1'b0, 1'b0);
    send_pair(16'sd0, 16'shAAAA, 1'b1, 1'b0);
    drain_results();

    short_items = 0;
    vec_idx     = 0;
    while (short_items < SHORT_ITEMS) begin
      if (vec_idx % 30 == 29) drain_results();

      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
      pick = $urandom_range(0, 99);
      if (pick < 30)      kind = VEC_RANDOM;
      else if (pick < 50) kind = VEC_SMALL;
      else if (pick < 65) kind = VEC_EXTREME;
      else if (pick < 75) kind = VEC_SAME;
      else if (pick < 83) kind = VEC_OPPOSITE;
      else if (pick < 89) kind = VEC_ZERO_A;
      else if (pick < 95) kind = VEC_ZERO_B;
      else if (pick < 98) kind = VEC_FULL_POS;
      else                kind = VEC_FULL_NEG;
      send_vector(len, kind, $urandom_range(0, 3) == 0);
      short_items += len;
      vec_idx++;
    end

    // Wait for the back stage to finish, then for stray results
    item_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d vector pairs in %0d element transactions.",
             tracker.vectors_done, tracker.pairs_seen);
    $display("Of these %0d zero-norm, %0d over-length, %0d clamped; %0d mismatches.",
             tracker.zero_done, tracker.long_done, tracker.clamped_done,
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/csu_pkg.sv
hdl/csu_front.sv
hdl/csu_queue.sv
hdl/csu_back.sv
hdl/cosine_similarity_unit.sv
dv/cosine_similarity_unit_test.sv
